// File: rtl/swd_pkg.sv
// Shared constants and types for the sliding window despike filter.
`timescale 1ns / 1ps
package swd_pkg;

  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_MAX_COLS   = 4096;
  localparam int DEF_MAX_ROWS   = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int COUNT_W    = 25;
  localparam int POS_W      = 12;
  localparam int FRAME_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Z_W        = 16;
  localparam int WCFG_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 2'd0,
    REG_Z      = 2'd1,
    REG_ROWS   = 2'd2,
    REG_COLS   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MATH,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

endpackage

// File: rtl/sliding_window_despike.sv
// Sliding window despike filter top. A border pixel is only stored and gives an empty result;
// an interior pixel is judged from its w*w window, read through the one line store port,
// and a spike center is replaced by the rounded neighbour mean from a bit-serial divider.
// A new pixel is taken only after the last result is loaded, so an output stall holds it.
// Reset: synchronous; clears counters, spike total and state. Line store
// contents stay undefined until written.
`timescale 1ns / 1ps
module sliding_window_despike
  import swd_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  center_valid,
  output logic [POS_W-1:0]      center_row,
  output logic [POS_W-1:0]      center_col,
  output logic [PIXEL_BITS-1:0] judged_value,
  output logic                  replaced,
  output logic [COUNT_W-1:0]    spike_count
);

  localparam int PB      = PIXEL_BITS;
  localparam int MAX_ODD = MAX_WINDOW - (((MAX_WINDOW % 2) == 0) ? 1 : 0);
  localparam int DEPTH   = MAX_WINDOW * MAX_COLS;
  localparam int ADW     = $clog2(DEPTH);
  localparam int RW      = $clog2(MAX_ROWS);
  localparam int CW      = $clog2(MAX_COLS);
  localparam int RSW     = $clog2(MAX_WINDOW);
  localparam int RSW2    = RSW + 2;
  localparam int WW      = $clog2(MAX_WINDOW + 1);
  localparam int NNW     = $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int SUMW    = PB + NNW;
  localparam int SQW     = 2 * PB + NNW;
  localparam int VW      = SQW + NNW;
  localparam int HV      = (VW + 1) / 2;
  localparam int HVH     = VW - HV;
  localparam int ZZW     = 2 * Z_W;
  localparam int RHW     = ZZW + VW;
  localparam int LHW     = 2 * SUMW + 16;
  localparam int CMPW    = (LHW > RHW) ? LHW : RHW;
  localparam int DW      = SUMW + 1;
  localparam int DCW     = $clog2(DW + 1);

  logic [PB-1:0] mem [DEPTH];
  logic [PB-1:0] rdata;

  state_t state, state_next;

  logic [WCFG_W-1:0]  win_cfg;
  logic [Z_W-1:0]     z_cfg;
  logic [FRAME_W-1:0] rows_cfg, cols_cfg;

  logic [RW-1:0]  row_counter;
  logic [CW-1:0]  col_counter;
  logic [RSW-1:0] row_slot;
  logic [COUNT_W-1:0] spike_total;

  logic [RW-1:0]  r_cur;
  logic [CW-1:0]  c_cur;
  logic [RSW-1:0] rs_cur;
  logic           interior;
  logic [WW-1:0]  i_cnt, j_cnt;
  logic           drain_cnt;
  logic           v1, c1, v2, c2;
  logic [PB-1:0]  p2;
  logic [2*PB-1:0] sq2;
  logic [SUMW-1:0] sum;
  logic [SQW-1:0]  sum2;
  logic [PB-1:0]   xc;
  logic [2:0]      step;
  logic [SUMW-1:0] nx;
  logic [2*SUMW-1:0] ssq;
  logic [ZZW-1:0]  zz;
  logic [SUMW-1:0] dabs;
  logic [VW-1:0]   nsum2;
  logic [2*SUMW-1:0] dd;
  logic [VW-1:0]   vv;
  logic [ZZW+HV-1:0]  pl;
  logic [ZZW+HVH-1:0] ph;
  logic            spike;
  logic [DW-1:0]   dnum, quo;
  logic [NNW:0]    rem;
  logic [DCW-1:0]  dcnt;
  logic [ADW-1:0]  cen_addr;

  logic [WW-1:0]  w_eff, h_eff, w_tmp;
  logic [NNW-1:0] nn;
  logic [FRAME_W-1:0] rows_eff, cols_eff;
  logic           accept;
  logic           restart;
  logic [RW-1:0]  r_new;
  logic [CW-1:0]  c_new;
  logic [RSW-1:0] rs_new;
  logic           interior_new;
  logic [RSW2-1:0] rd_slot, cen_slot;
  logic [ADW-1:0] rd_addr, wr_addr_pix, cen_addr_new;
  logic           rd_en;
  logic           wr_en;
  logic [ADW-1:0] wr_addr;
  logic [PB-1:0]  wr_data;
  logic           last_read;
  logic           spike_cmp;
  logic [CMPW-1:0] lhs, rhs;
  logic [NNW:0]   rem_sh;
  logic           load_out;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    if (win_cfg < WCFG_W'(3)) begin
      w_tmp = WW'(3);
    end else if (!win_cfg[0]) begin
      w_tmp = WW'(win_cfg - WCFG_W'(1));
    end else begin
      w_tmp = WW'(win_cfg);
    end
    w_eff = (w_tmp > WW'(MAX_ODD)) ? WW'(MAX_ODD) : w_tmp;
    h_eff = w_eff >> 1;
    nn    = NNW'(w_eff * w_eff - 1);
  end

  always_comb begin
    if (rows_cfg == '0) begin
      rows_eff = FRAME_W'(1);
    end else if (rows_cfg > FRAME_W'(MAX_ROWS)) begin
      rows_eff = FRAME_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg;
    end
    if (cols_cfg == '0) begin
      cols_eff = FRAME_W'(1);
    end else if (cols_cfg > FRAME_W'(MAX_COLS)) begin
      cols_eff = FRAME_W'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg;
    end
  end

  always_comb begin
    restart = frame_start || (FRAME_W'(row_counter) >= rows_eff)
              || (FRAME_W'(col_counter) >= cols_eff);
    r_new  = restart ? '0 : row_counter;
    c_new  = restart ? '0 : col_counter;
    rs_new = restart ? '0 : row_slot;
    interior_new = (RW'(2 * h_eff) <= r_new) && (CW'(2 * h_eff) <= c_new);
    wr_addr_pix  = ADW'(ADW'(rs_new) * ADW'(MAX_COLS) + ADW'(c_new));
    cen_slot = RSW2'(rs_new) + RSW2'(MAX_WINDOW) - RSW2'(h_eff);
    if (cen_slot >= RSW2'(MAX_WINDOW)) begin
      cen_slot = cen_slot - RSW2'(MAX_WINDOW);
    end
    cen_addr_new = ADW'(ADW'(cen_slot) * ADW'(MAX_COLS)
                   + ADW'(c_new - CW'(h_eff)));
  end

  always_comb begin
    rd_slot = RSW2'(rs_cur) + RSW2'(MAX_WINDOW) - RSW2'(2 * h_eff) + RSW2'(i_cnt);
    if (rd_slot >= RSW2'(MAX_WINDOW)) begin
      rd_slot = rd_slot - RSW2'(MAX_WINDOW);
    end
    rd_addr = ADW'(ADW'(rd_slot) * ADW'(MAX_COLS)
              + ADW'(c_cur - CW'(2 * h_eff) + CW'(j_cnt)));
    last_read = (i_cnt == w_eff - WW'(1)) && (j_cnt == w_eff - WW'(1));
  end

  always_comb begin
    lhs = CMPW'({dd, 16'd0});
    rhs = CMPW'(pl) + (CMPW'(ph) << HV);
    spike_cmp = lhs > rhs;
    rem_sh = {rem[NNW-1:0], dnum[DW-1]};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = interior_new ? ST_READ : ST_DONE;
      ST_READ:  if (last_read) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_cnt) state_next = ST_MATH;
      ST_MATH:  if (step == 3'd5) state_next = spike_cmp ? ST_DIV : ST_DONE;
      ST_DIV:   if (dcnt == DCW'(DW - 1)) state_next = ST_WB;
      ST_WB:    state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = wr_addr_pix;
    wr_data  = pixel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_valid;
      end
      ST_READ: rd_en = 1'b1;
      ST_WB: begin
        wr_en   = 1'b1;
        wr_addr = cen_addr;
        wr_data = quo[PB-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg  <= WCFG_W'(3);
      z_cfg    <= Z_W'(768);
      rows_cfg <= FRAME_W'(4096);
      cols_cfg <= FRAME_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW: win_cfg  <= cfg_data[WCFG_W-1:0];
        REG_Z:      z_cfg    <= cfg_data[Z_W-1:0];
        REG_ROWS:   rows_cfg <= cfg_data[FRAME_W-1:0];
        REG_COLS:   cols_cfg <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_counter <= '0;
      col_counter <= '0;
      row_slot    <= '0;
      spike_total <= '0;
      out_valid   <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= rd_en;
      v2    <= v1;
      if (accept) begin
        if (r_new == '0 && c_new == '0) spike_total <= '0;
        if (FRAME_W'(c_new) + FRAME_W'(1) >= cols_eff) begin
          col_counter <= '0;
          if (FRAME_W'(r_new) + FRAME_W'(1) >= rows_eff) begin
            row_counter <= '0;
            row_slot    <= '0;
          end else begin
            row_counter <= r_new + RW'(1);
            row_slot    <= (rs_new == RSW'(MAX_WINDOW - 1)) ? '0 : rs_new + RSW'(1);
          end
        end else begin
          col_counter <= c_new + CW'(1);
          row_counter <= r_new;
          row_slot    <= rs_new;
        end
      end
      if (state == ST_WB && spike_total != {COUNT_W{1'b1}}) begin
        spike_total <= spike_total + COUNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c1 <= (i_cnt == h_eff) && (j_cnt == h_eff);
    c2 <= c1;
    p2  <= rdata;
    sq2 <= rdata * rdata;
    if (accept) begin
      r_cur    <= r_new;
      c_cur    <= c_new;
      rs_cur   <= rs_new;
      interior <= interior_new;
      cen_addr <= cen_addr_new;
      i_cnt    <= '0;
      j_cnt    <= '0;
      sum      <= '0;
      sum2     <= '0;
      spike    <= 1'b0;
      drain_cnt <= 1'b0;
      step     <= '0;
    end
    if (state == ST_READ) begin
      if (j_cnt == w_eff - WW'(1)) begin
        j_cnt <= '0;
        i_cnt <= i_cnt + WW'(1);
      end else begin
        j_cnt <= j_cnt + WW'(1);
      end
    end
    if (state == ST_DRAIN) drain_cnt <= 1'b1;
    if (v2) begin
      if (c2) begin
        xc <= p2;
      end else begin
        sum  <= sum + SUMW'(p2);
        sum2 <= sum2 + SQW'(sq2);
      end
    end
    if (state == ST_MATH) begin
      step <= step + 3'd1;
      case (step)
        3'd0: begin
          nx  <= SUMW'(nn) * SUMW'(xc);
          ssq <= sum * sum;
          zz  <= z_cfg * z_cfg;
        end
        3'd1: begin
          dabs  <= (nx >= sum) ? nx - sum : sum - nx;
          nsum2 <= VW'(nn) * VW'(sum2);
        end
        3'd2: begin
          dd <= dabs * dabs;
          vv <= nsum2 - VW'(ssq);
        end
        3'd3: pl <= (ZZW+HV)'(zz) * (ZZW+HV)'(vv[HV-1:0]);
        3'd4: ph <= (ZZW+HVH)'(zz) * (ZZW+HVH)'(vv[VW-1:HV]);
        3'd5: begin
          spike <= spike_cmp;
          dnum  <= DW'(sum) + DW'(nn >> 1);
          rem   <= '0;
          quo   <= '0;
          dcnt  <= '0;
        end
        default: ;
      endcase
    end
    if (state == ST_DIV) begin
      dcnt <= dcnt + DCW'(1);
      dnum <= dnum << 1;
      if (rem_sh >= (NNW+1)'(nn)) begin
        rem <= rem_sh - (NNW+1)'(nn);
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
    if (load_out) begin
      center_valid <= interior;
      center_row   <= interior ? POS_W'(r_cur - RW'(h_eff)) : '0;
      center_col   <= interior ? POS_W'(c_cur - CW'(h_eff)) : '0;
      judged_value <= !interior ? '0 : (spike ? quo[PB-1:0] : xc);
      replaced     <= interior && spike;
      spike_count  <= spike_total;
    end
  end

endmodule

// File: rtl/swd_checker.sv
// Port-level checks for the sliding window despike filter.
`timescale 1ns / 1ps
module swd_checker
  import swd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               center_valid,
  input logic               replaced,
  input logic [COUNT_W-1:0] spike_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_rep_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> center_valid)
    else $error("replacement flagged without a judged center");

  a_rep_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> spike_count != '0)
    else $error("replacement not counted");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind sliding_window_despike swd_checker u_swd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .center_valid (center_valid),
  .replaced     (replaced),
  .spike_count  (spike_count)
);
